// ===== sv/tea_pkg.sv =====
`timescale 1ns / 1ps
// tea_pkg: shared types, constants and the round mix function for the TEA cipher.
// No dependencies; used by every module of the block.
package tea_pkg;

  localparam logic [31:0] DELTA = 32'h9e3779b9;
  localparam int unsigned WORD_W = 32;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

  // request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  // one classified request
  typedef struct packed {
    logic              dec;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } tea_item_t;

  function automatic logic [WORD_W-1:0] mix(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

// ===== sv/tea_block_cipher_top.sv =====
`timescale 1ns / 1ps
// tea_block_cipher_top: TEA block cipher, 128-bit key, ROUND_COUNT rounds, pipelined.
// Depends on tea_pkg, tea_front, tea_queue and tea_back.
//
//   channel  handshake           payload
//   in       in_valid/in_stall   in_kind, in_block_left, in_block_right
//   out      out_valid/out_stall out_result_left, out_result_right
//   cfg      cfg_we              cfg_index, cfg_wdata (key words 0..3)
//
// Sustained rate is one request per cycle while the pipe is not frozen: every half-round
// owns a register stage, so up to 2*ROUND_COUNT + 1 requests sit in the round pipeline
// (entry plus halves). From accept to out_valid a request passes the front register, the
// queue, the pipe entry and then one register per half-round.
// rst_n is synchronous; it clears valids, queue pointers and the key words.
// out_stall with out_valid high freezes the round pipe; the front and the 4-entry
// queue keep taking requests until the queue fills, then in_stall rises.
module tea_block_cipher_top #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [31:0]                   in_block_left,
  input  logic [31:0]                   in_block_right,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   out_result_left,
  output logic [31:0]                   out_result_right,
  input  logic                          cfg_we,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);

  tea_pkg::tea_key_t  key_r, key_nxt;
  tea_pkg::tea_item_t push_item;
  tea_pkg::tea_item_t pop_item;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_not_empty;

  // key words: to be written only while idle, which the block does not enforce; read live by every round stage
  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      case (cfg_index)
        tea_pkg::REG_KEY0: key_nxt.k0 = cfg_wdata;
        tea_pkg::REG_KEY1: key_nxt.k1 = cfg_wdata;
        tea_pkg::REG_KEY2: key_nxt.k2 = cfg_wdata;
        tea_pkg::REG_KEY3: key_nxt.k3 = cfg_wdata;
        default:           key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // front: take and classify requests
  tea_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_block_left  (in_block_left),
    .in_block_right (in_block_right),
    .push           (push),
    .push_item      (push_item),
    .q_full         (q_full)
  );

  // decouples the front from stalls of the round pipe
  tea_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  // back: the rounds themselves; final stage doubles as output register
  tea_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .key              (key_r),
    .q_not_empty      (q_not_empty),
    .pop              (pop),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_left  (out_result_left),
    .out_result_right (out_result_right)
  );

endmodule

// ===== sv/tea_front.sv =====
`timescale 1ns / 1ps
// tea_front: input register that takes requests and decodes the operation kind.
// Depends on tea_pkg; feeds tea_queue.
module tea_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [31:0]               in_block_left,
  input  logic [31:0]               in_block_right,
  output logic                      push,
  output tea_pkg::tea_item_t        push_item,
  input  logic                      q_full
);

  logic               vld_r, vld_nxt;
  tea_pkg::tea_item_t item_r;

  // hold only while the queue cannot take the registered request
  assign in_stall  = vld_r & q_full;
  assign push      = vld_r & ~q_full;
  assign push_item = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (!in_stall) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.dec <= in_kind;
      item_r.y   <= in_block_left;
      item_r.z   <= in_block_right;
    end
  end

endmodule

// ===== sv/tea_queue.sv =====
`timescale 1ns / 1ps
// tea_queue: short FIFO of classified requests between front and back.
// Depends on tea_pkg.
module tea_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tea_pkg::tea_item_t push_item,
  output logic               full,
  output logic               not_empty,
  input  logic               pop,
  output tea_pkg::tea_item_t pop_item
);

  tea_pkg::tea_item_t               mem_r [tea_pkg::QUEUE_DEPTH];
  logic [tea_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [tea_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [tea_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == tea_pkg::QCNT_W'(tea_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/tea_back.sv =====
`timescale 1ns / 1ps
// tea_back: round pipeline, one register stage per half-round, last stage is the output.
// Depends on tea_pkg; pulls requests from tea_queue.
module tea_back #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tea_pkg::tea_key_t  key,
  input  logic               q_not_empty,
  output logic               pop,
  input  tea_pkg::tea_item_t pop_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_result_left,
  output logic [31:0]        out_result_right
);

  localparam int unsigned NUM_HALF = 2 * ROUND_COUNT;

  logic        vld_r [NUM_HALF+1];
  logic        dec_r [NUM_HALF+1];
  logic [31:0] y_r   [NUM_HALF+1];
  logic [31:0] z_r   [NUM_HALF+1];
  logic [31:0] y_nxt [NUM_HALF];
  logic [31:0] z_nxt [NUM_HALF];
  logic        adv;

  // whole pipe moves unless the finished result is held
  assign adv = ~(vld_r[NUM_HALF] & out_stall);
  assign pop = adv & q_not_empty;

  assign out_valid        = vld_r[NUM_HALF];
  assign out_result_left  = y_r[NUM_HALF];
  assign out_result_right = z_r[NUM_HALF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dec_r[0] <= pop_item.dec;
      y_r[0]   <= pop_item.y;
      z_r[0]   <= pop_item.z;
    end
  end

  for (genvar h = 0; h < NUM_HALF; h++) begin : g_half
    localparam int unsigned RND = h / 2;
    localparam bit          ODD = (h % 2) == 1;
    localparam logic [31:0] SUM_ENC = tea_pkg::DELTA * 32'(RND + 1);
    localparam logic [31:0] SUM_DEC = tea_pkg::DELTA * 32'(ROUND_COUNT - RND);

    logic        use_z;
    logic [31:0] src;
    logic [31:0] sum;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] m;

    // encrypt: even half updates y from z, odd half z from y; decrypt swaps the order
    always_comb begin
      use_z = ODD ? dec_r[h] : ~dec_r[h];
      src   = use_z ? z_r[h] : y_r[h];
      sum   = dec_r[h] ? SUM_DEC : SUM_ENC;
      ka    = use_z ? key.k0 : key.k2;
      kb    = use_z ? key.k1 : key.k3;
      m     = tea_pkg::mix(src, sum, ka, kb);
      y_nxt[h] = y_r[h];
      z_nxt[h] = z_r[h];
      if (use_z) begin
        y_nxt[h] = dec_r[h] ? (y_r[h] - m) : (y_r[h] + m);
      end else begin
        z_nxt[h] = dec_r[h] ? (z_r[h] - m) : (z_r[h] + m);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[h+1] <= 1'b0;
      end else if (adv) begin
        vld_r[h+1] <= vld_r[h];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dec_r[h+1] <= dec_r[h];
        y_r[h+1]   <= y_nxt[h];
        z_r[h+1]   <= z_nxt[h];
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for tea_block_cipher_top (TEA, 128-bit key, 32 rounds).
// Depends on tea_pkg and tea_block_cipher_top; carries its own TEA predictor.
module testbench;

  localparam int unsigned ROUNDS       = 32;
  // accept to out_valid with no stalls
  localparam int unsigned PIPE_LATENCY = 2 * ROUNDS + 2;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 212;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_DIRECTED = 12;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } block_pair_t;

  // one directed request; known rows carry a typed-in answer
  typedef struct packed {
    logic        kind;
    logic [31:0] left;
    logic [31:0] right;
    logic        known;
    logic [31:0] exp_left;
    logic [31:0] exp_right;
  } directed_row_t;

  // Zero key throughout. The all-zero block under the all-zero key is the
  // classic TEA vector, and its decryption must come back to zero.
  localparam directed_row_t DIRECTED [NUM_DIRECTED] = '{
    '{1'b0, 32'h00000000, 32'h00000000, 1'b1, 32'h41ea3a0a, 32'h94baa940},
    '{1'b1, 32'h41ea3a0a, 32'h94baa940, 1'b1, 32'h00000000, 32'h00000000},
    '{1'b0, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
    '{1'b1, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h00000000, 32'hffffffff, 1'b0, 32'h0, 32'h0},
    '{1'b1, 32'hffffffff, 32'h00000000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h80000000, 32'h00000001, 1'b0, 32'h0, 32'h0},
    '{1'b1, 32'h00000001, 32'h80000000, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'haaaaaaaa, 32'h55555555, 1'b0, 32'h0, 32'h0},
    '{1'b1, 32'h55555555, 32'haaaaaaaa, 1'b0, 32'h0, 32'h0},
    '{1'b0, 32'h01234567, 32'h89abcdef, 1'b0, 32'h0, 32'h0},
    '{1'b1, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_kind;
  logic [31:0]                   in_block_left;
  logic [31:0]                   in_block_right;
  logic                          out_valid;
  logic                          out_stall;
  logic [31:0]                   out_result_left;
  logic [31:0]                   out_result_right;
  logic                          cfg_we;
  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                   cfg_wdata;

  // key as the block should hold it, and the blocks still owed by the block
  tea_pkg::tea_key_t cur_key;
  block_pair_t       expected_blocks[$];

  // idle percentages for sender and receiver, set per phase
  int unsigned send_pct;
  int unsigned recv_pct;

  int unsigned blocks_sent;
  int unsigned results_checked;
  int unsigned error_count;

  tea_block_cipher_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_block_left    (in_block_left),
    .in_block_right   (in_block_right),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_left  (out_result_left),
    .out_result_right (out_result_right),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // half-round term: (x<<4 + ka) ^ (x + sum) ^ (x>>5 + kb), all mod 2^32
  function automatic logic [31:0] round_term(
    input logic [31:0] x,
    input logic [31:0] sum,
    input logic [31:0] ka,
    input logic [31:0] kb
  );
    logic [31:0] hi;
    logic [31:0] lo;
    hi = (x << 4) + ka;
    lo = (x >> 5) + kb;
    return hi ^ (x + sum) ^ lo;
  endfunction

  // full TEA transform: encrypt walks the sum up from zero, decrypt walks
  // it down from DELTA*ROUNDS and undoes the half-rounds in reverse order
  function automatic block_pair_t tea_cipher(
    input logic              dec,
    input logic [31:0]       y_in,
    input logic [31:0]       z_in,
    input tea_pkg::tea_key_t key
  );
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    y = y_in;
    z = z_in;
    if (!dec) begin
      sum = 32'h0;
      for (int n = 0; n < ROUNDS; n++) begin
        sum = sum + tea_pkg::DELTA;
        y   = y + round_term(z, sum, key.k0, key.k1);
        z   = z + round_term(y, sum, key.k2, key.k3);
      end
    end else begin
      sum = tea_pkg::DELTA * ROUNDS;
      for (int n = 0; n < ROUNDS; n++) begin
        z   = z - round_term(y, sum, key.k2, key.k3);
        y   = y - round_term(z, sum, key.k0, key.k1);
        sum = sum - tea_pkg::DELTA;
      end
    end
    return '{left: y, right: z};
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // random word, biased toward the edges of the range
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h00000000;
      1: return 32'hffffffff;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // key for each phase: extremes and one fixed bit pattern, the rest random
  function automatic tea_pkg::tea_key_t phase_key(input int p);
    case (p)
      1, 7: return '{k0: '1, k1: '1, k2: '1, k3: '1};
      4: return '{k0: '0, k1: '0, k2: '0, k3: '0};
      5: return '{k0: 32'h80000000, k1: 32'h00000001,
                  k2: 32'h7fffffff, k3: 32'hfffffffe};
      default: return '{k0: $urandom(), k1: $urandom(), k2: $urandom(), k3: $urandom()};
    endcase
  endfunction

  // Present one request. Gaps are drawn first; valid only drops at a gap,
  // so back-to-back requests keep valid high with one assignment per edge.
  // The payload holds while in_stall is up. On accept the expected block
  // is queued: the typed-in answer if given, else the predictor's.
  task automatic send_block(
    input logic        kind,
    input logic [31:0] left,
    input logic [31:0] right,
    input logic        known,
    input block_pair_t answer
  );
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_block_left  <= left;
    in_block_right <= right;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_blocks.push_back(known ? answer : tea_cipher(kind, left, right, cur_key));
    blocks_sent++;
  endtask

  // drop valid, then wait until every owed block is out and the pipe is quiet
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // write all four key words, one per cycle, only while the block is idle
  task automatic load_key(input tea_pkg::tea_key_t k);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= tea_pkg::REG_KEY0;
    cfg_wdata <= k.k0;
    @(negedge clk);
    cfg_index <= tea_pkg::REG_KEY1;
    cfg_wdata <= k.k1;
    @(negedge clk);
    cfg_index <= tea_pkg::REG_KEY2;
    cfg_wdata <= k.k2;
    @(negedge clk);
    cfg_index <= tea_pkg::REG_KEY3;
    cfg_wdata <= k.k3;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_key = k;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall, changed on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // ---------------------------------------------------------------------
  // Checker: each delivered block against the oldest expected one
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    block_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR %0t: unexpected result left=%h right=%h",
                   $realtime, out_result_left, out_result_right);
      end else begin
        want = expected_blocks.pop_front();
        results_checked++;
        if (out_result_left !== want.left || out_result_right !== want.right) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR %0t: left exp=%h got=%h, right exp=%h got=%h",
                     $realtime, want.left, out_result_left, want.right, out_result_right);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    block_pair_t last_cipher;
    logic        have_cipher;
    logic        kind;
    logic [31:0] left;
    logic [31:0] right;

    // every input known from time zero; reset held low, then released on a falling edge
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = 1'b0;
    in_block_left  = 32'h0;
    in_block_right = 32'h0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = tea_pkg::REG_KEY0;
    cfg_wdata      = 32'h0;
    send_pct       = 0;
    recv_pct       = 0;
    cur_key        = '0;
    have_cipher    = 1'b0;
    last_cipher    = '0;
    blocks_sent     = 0;
    results_checked = 0;
    error_count     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows against the reset (all-zero) key, no idling
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_block(DIRECTED[i].kind, DIRECTED[i].left, DIRECTED[i].right, DIRECTED[i].known,
                 '{left: DIRECTED[i].exp_left, right: DIRECTED[i].exp_right});

    // Random phases. Each new key is loaded with the pipe empty. Flow
    // control cycles through: none, sender idle, receiver stall, both.
    // A fifth of the requests decrypt the last ciphertext (round trip).
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain_pipe();
        load_key(phase_key(p));
        have_cipher = 1'b0;
      end
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 67; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 67; end
        default: begin send_pct = 30; recv_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (have_cipher && $urandom_range(9) < 2) begin
          send_block(1'b1, last_cipher.left, last_cipher.right, 1'b0, '0);
        end else begin
          kind  = 1'($urandom_range(1));
          left  = pick_word();
          right = pick_word();
          send_block(kind, left, right, 1'b0, '0);
          if (!kind) begin
            last_cipher = tea_cipher(1'b0, left, right, cur_key);
            have_cipher = 1'b1;
          end
        end
      end
    end

    // let the receiver run free for the tail
    send_pct = 0;
    recv_pct = 0;
    drain_pipe();

    $display("testbench: %0d blocks in (%0d directed), %0d checked, %0d errors",
             blocks_sent, NUM_DIRECTED, results_checked, error_count);
    $display("testbench: %0d key phases (zero, all-ones, patterns, random) under four flow modes",
             NUM_PHASES);
    if (error_count == 0 && expected_blocks.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("testbench: timeout with %0d blocks outstanding", expected_blocks.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tea_pkg.sv
sv/tea_front.sv
sv/tea_queue.sv
sv/tea_back.sv
sv/tea_block_cipher_top.sv
bench/testbench.sv
